// File: design/bsts_pkg.sv
// ----------------------------------------------------------------------------
// bsts_pkg
// shared constants, rule tables and window match functions for the
// binary shrink / thin / skeleton pass
// ----------------------------------------------------------------------------
`default_nettype none

package bsts_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT + 3) + 1;
  localparam int CFG_W = 11;
  localparam int IDX_W = 2;

  localparam logic [IDX_W-1:0] REG_OP_MODE      = 2'd0;
  localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

  localparam logic [1:0] MODE_SHRINK   = 2'd0;
  localparam logic [1:0] MODE_THIN     = 2'd1;
  localparam logic [1:0] MODE_SKELETON = 2'd2;

  localparam logic [CFG_W-1:0] RST_WIDTH  = 11'd640;
  localparam logic [CFG_W-1:0] RST_HEIGHT = 11'd480;

  // tables written in reading order: top-left first, bottom-right last
  localparam logic [8:0] TAB_S_LOW [20] = '{
    9'b001010000, 9'b100010000, 9'b000010100, 9'b000010001, 9'b000011000,
    9'b010010000, 9'b000110000, 9'b000010010, 9'b001011000, 9'b011010000,
    9'b110010000, 9'b100110000, 9'b000110100, 9'b000010110, 9'b000010011,
    9'b000011001, 9'b001011001, 9'b111010000, 9'b100110100, 9'b000010111};
  localparam logic [8:0] TAB_TK4 [8] = '{
    9'b010011000, 9'b010110000, 9'b000110010, 9'b000011010,
    9'b001011001, 9'b111010000, 9'b100110100, 9'b000010111};
  localparam logic [8:0] TAB_ST5 [10] = '{
    9'b110011000, 9'b010011001, 9'b011110000, 9'b001011010, 9'b011011000,
    9'b110110000, 9'b000110110, 9'b000011011, 9'b110011001, 9'b011110100};
  localparam logic [8:0] TAB_STK [28] = '{
    9'b111011000, 9'b011011001, 9'b111110000, 9'b110110100, 9'b100110110,
    9'b000110111, 9'b000011111, 9'b001011011, 9'b111011001, 9'b111110100,
    9'b100110111, 9'b001011111, 9'b011011011, 9'b111111000, 9'b110110110,
    9'b000111111, 9'b111011011, 9'b011011111, 9'b111111100, 9'b111111001,
    9'b111110110, 9'b110110111, 9'b100111111, 9'b001111111, 9'b111011111,
    9'b111111101, 9'b111110111, 9'b101111111};
  localparam logic [8:0] TAB_K11 [4] = '{
    9'b111111011, 9'b111111110, 9'b110111111, 9'b011111111};
  localparam logic [8:0] TAB_ST_UNC [24] = '{
    9'b001010000, 9'b100010000, 9'b000010010, 9'b000011000, 9'b001011000,
    9'b011010000, 9'b110010000, 9'b100110000, 9'b000110100, 9'b000010110,
    9'b000010011, 9'b000011001, 9'b011010100, 9'b001011100, 9'b100110001,
    9'b110010001, 9'b001110100, 9'b001010110, 9'b100010011, 9'b100011001,
    9'b011110000, 9'b110011000, 9'b010011001, 9'b001011010};
  localparam logic [8:0] TAB_K_UNC [12] = '{
    9'b001010000, 9'b100010000, 9'b000010001, 9'b000010100, 9'b000010010,
    9'b000011000, 9'b000110000, 9'b010010000, 9'b010011000, 9'b010110000,
    9'b000011010, 9'b000110010};

  // window bit k is neighbor k in raster order, so reverse the table literal
  function automatic logic [8:0] rev9(input logic [8:0] x);
    return {x[0], x[1], x[2], x[3], x[4], x[5], x[6], x[7], x[8]};
  endfunction

  function automatic logic in_s_low(input logic [8:0] w);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < 20; i++) hit = hit | (rev9(TAB_S_LOW[i]) == w);
    return hit;
  endfunction

  function automatic logic in_tk4(input logic [8:0] w);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < 8; i++) hit = hit | (rev9(TAB_TK4[i]) == w);
    return hit;
  endfunction

  function automatic logic in_st5(input logic [8:0] w);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < 10; i++) hit = hit | (rev9(TAB_ST5[i]) == w);
    return hit;
  endfunction

  function automatic logic in_stk(input logic [8:0] w);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < 28; i++) hit = hit | (rev9(TAB_STK[i]) == w);
    return hit;
  endfunction

  function automatic logic in_k11(input logic [8:0] w);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < 4; i++) hit = hit | (rev9(TAB_K11[i]) == w);
    return hit;
  endfunction

  function automatic logic in_st_unc(input logic [8:0] w);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < 24; i++) hit = hit | (rev9(TAB_ST_UNC[i]) == w);
    return hit;
  endfunction

  function automatic logic in_k_unc(input logic [8:0] w);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < 12; i++) hit = hit | (rev9(TAB_K_UNC[i]) == w);
    return hit;
  endfunction

  function automatic logic none3(input logic [8:0] w, input int a, input int b, input int c);
    return !w[a] && !w[b] && !w[c];
  endfunction

  function automatic logic tee_st(input logic [8:0] w);
    logic hit;
    hit = 1'b0;
    if (w[3] && w[4] && w[5]) begin
      if (w[1]) hit = none3(w, 2, 7, 8) || none3(w, 0, 6, 7);
      else if (w[7]) hit = none3(w, 0, 1, 6) || none3(w, 1, 2, 8);
    end else if (w[1] && w[4] && w[7]) begin
      if (w[3]) hit = none3(w, 5, 6, 8) || none3(w, 0, 2, 5);
      else if (w[5]) hit = none3(w, 0, 2, 3) || none3(w, 3, 6, 8);
    end
    return hit;
  endfunction

  function automatic logic tee_k(input logic [8:0] w);
    logic hit;
    hit = 1'b0;
    if (w[3] && w[4] && w[5]) hit = w[1] || w[7];
    else if (w[1] && w[4] && w[7]) hit = w[3] || w[5];
    return hit;
  endfunction

  function automatic logic vee(input logic [8:0] w);
    return (w[0] && w[2] && w[4] && (w[6] || w[7] || w[8])) ||
           (w[0] && w[4] && w[6] && (w[2] || w[5] || w[8])) ||
           (w[4] && w[6] && w[8] && (w[0] || w[1] || w[2])) ||
           (w[2] && w[4] && w[8] && (w[0] || w[3] || w[6]));
  endfunction

  function automatic logic diag(input logic [8:0] w);
    return (w[1] && w[4] && w[5] && w[6] && none3(w, 2, 3, 7)) ||
           (w[1] && w[3] && w[4] && w[8] && none3(w, 0, 5, 7)) ||
           (w[2] && w[3] && w[4] && w[7] && none3(w, 1, 5, 6)) ||
           (w[0] && w[4] && w[5] && w[7] && none3(w, 1, 3, 8));
  endfunction

  function automatic logic cond_hit(input logic [8:0] w, input logic [1:0] mode);
    logic hit;
    case (mode)
      MODE_SHRINK:   hit = in_s_low(w) || in_st5(w) || in_stk(w);
      MODE_THIN:     hit = in_tk4(w) || in_st5(w) || in_stk(w);
      MODE_SKELETON: hit = in_tk4(w) || in_stk(w) || in_k11(w);
      default:       hit = 1'b0;
    endcase
    return hit;
  endfunction

  function automatic logic unc_hit(input logic [8:0] w, input logic [1:0] mode);
    logic hit;
    if (mode == MODE_SKELETON) begin
      hit = in_k_unc(w) || (w[0] && w[1] && w[3] && w[4]) ||
            (w[4] && w[5] && w[7] && w[8]) || tee_k(w);
    end else begin
      hit = in_st_unc(w) || (w[0] && w[1] && w[3] && w[4]) || tee_st(w);
    end
    return hit || vee(w) || diag(w);
  endfunction

endpackage

`default_nettype wire

// File: design/bsts_ram.sv
// ----------------------------------------------------------------------------
// bsts_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module bsts_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: design/binary_shrink_thin_skeleton_pass.sv
// ----------------------------------------------------------------------------
// binary_shrink_thin_skeleton_pass
// one raster pass of hit-or-miss shrinking, thinning or skeletonizing
// ----------------------------------------------------------------------------
// Pixels stream in raster order, one transaction per clock when neither side
// stalls. Each frame takes width*height pixels followed by 2*width+2 padding
// transactions; results start once two rows and two pixels have gone in, one
// per input transaction after that, the last one flagged with last_of_frame
// and frame_changed. Two line rams hold the state: a pixel ram (one entry per
// column, the two previous rows) and a mark ram (marks and center pixels of
// the two previous mark rows). Each ram is read when a transaction enters a
// stage and written back when it leaves that stage, so an item passes the
// block in order: accept with pixel ram read, mark match with mark ram read,
// delete match into the output register. Since a column recurs only every
// width (at least 3) transactions, read and write-back never collide.
// Configuration must go in only while no frame is in flight; the block does
// not enforce this. Pixel and mark windows outside the image read as zero.
// Out-of-range width and height clamp to 3..1024.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_shrink_thin_skeleton_pass (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [bsts_pkg::IDX_W-1:0] cfg_index_i,
  input  wire logic [bsts_pkg::CFG_W-1:0] cfg_data_i,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic                       pixel_in_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic                            pixel_out_o,
  output logic                            deleted_o,
  output logic                            last_of_frame_o,
  output logic                            frame_changed_o
);

  import bsts_pkg::*;

  // configuration
  logic [1:0]       op_mode_q;
  logic [CFG_W-1:0] frame_width_q, frame_height_q;
  logic [CFG_W-1:0] eff_w, eff_h;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_mode_q      <= MODE_SHRINK;
      frame_width_q  <= RST_WIDTH;
      frame_height_q <= RST_HEIGHT;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_OP_MODE:      op_mode_q      <= cfg_data_i[1:0];
        REG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
        REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (frame_width_q < 11'd3) eff_w = 11'd3;
    else if (frame_width_q > CFG_W'(MAX_WIDTH)) eff_w = CFG_W'(MAX_WIDTH);
    else eff_w = frame_width_q;
    if (frame_height_q < 11'd3) eff_h = 11'd3;
    else if (frame_height_q > CFG_W'(MAX_HEIGHT)) eff_h = CFG_W'(MAX_HEIGHT);
    else eff_h = frame_height_q;
  end

  // whole pipe moves together whenever the output register can take a result
  logic adv, accept;
  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;
  assign accept     = in_valid_i && adv;

  // ---------------- stage 0: position counters ----------------
  logic [ROW_W-1:0] row_q, row_d, r0, h_end;
  logic [COL_W-1:0] col_q, col_d, c0;
  logic             restart, last_pos, outv0, first0;
  logic [CFG_W-1:0] c0_inc;

  always_comb begin
    h_end   = ROW_W'(eff_h) + ROW_W'(2);
    restart = ({1'b0, col_q} >= eff_w) || (row_q > h_end) ||
              (row_q == h_end && col_q > COL_W'(1));
    r0       = restart ? '0 : row_q;
    c0       = restart ? '0 : col_q;
    c0_inc   = {1'b0, c0} + CFG_W'(1);
    last_pos = (r0 == h_end) && (c0 == COL_W'(1));
    first0   = (r0 == '0) && (c0 == '0);
    outv0    = ((r0 > ROW_W'(2)) || (r0 == ROW_W'(2) && c0 >= COL_W'(2))) &&
               ((r0 < h_end) || (c0 < COL_W'(2)));
    row_d    = row_q;
    col_d    = col_q;
    if (accept) begin
      if (last_pos) begin
        row_d = '0;
        col_d = '0;
      end else if (c0_inc == eff_w) begin
        row_d = r0 + ROW_W'(1);
        col_d = '0;
      end else begin
        row_d = r0;
        col_d = c0_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // ---------------- stage 1: pixel window and marking ----------------
  logic             s1_valid_q, s1_pix_q, s1_outv_q, s1_last_q, s1_first_q;
  logic [ROW_W-1:0] s1_row_q;
  logic [COL_W-1:0] s1_col_q;
  logic [1:0]       pix_rdata;
  logic             s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      // rows past the image store zero
      s1_pix_q   <= pixel_in_i && (r0 < ROW_W'(eff_h));
      s1_row_q   <= r0;
      s1_col_q   <= c0;
      s1_outv_q  <= outv0;
      s1_last_q  <= last_pos;
      s1_first_q <= first0;
    end
  end

  assign s1_fire = s1_valid_q && adv;

  // pixel ram entry: [0] row above, [1] two rows above
  bsts_ram #(.WIDTH(2), .DEPTH(MAX_WIDTH)) u_pix_ram (
    .clk_i   (clk_i),
    .we_i    (s1_fire),
    .waddr_i (s1_col_q),
    .wdata_i ({pix_rdata[0], s1_pix_q}),
    .re_i    (accept),
    .raddr_i (c0),
    .rdata_o (pix_rdata)
  );

  // column registers: {top, mid, bottom}
  logic [2:0]       pl_q, pm_q, pn;
  logic [2:0]       p_left, p_mid, p_right, p_rowm;
  logic [8:0]       pwin;
  logic             p_c0, qvalid, pixc, mark;
  logic [ROW_W-1:0] qr2;
  logic [COL_W-1:0] mc;

  always_comb begin
    pn   = {pix_rdata[1], pix_rdata[0], s1_pix_q};
    p_c0 = (s1_col_q == '0);
    if (!p_c0) begin
      p_rowm  = {s1_row_q >= ROW_W'(2), s1_row_q >= ROW_W'(1), 1'b1};
      p_left  = (s1_col_q == COL_W'(1)) ? 3'b000 : pl_q;
      p_right = pn;
      qvalid  = (s1_row_q >= ROW_W'(1)) && (s1_row_q <= ROW_W'(eff_h));
      qr2     = s1_row_q + ROW_W'(1);
      mc      = s1_col_q - COL_W'(1);
    end else begin
      // row start: the window centers on the last pixel of the row two above
      p_rowm  = {s1_row_q >= ROW_W'(3), s1_row_q >= ROW_W'(2), s1_row_q >= ROW_W'(1)};
      p_left  = pl_q;
      p_right = 3'b000;
      qvalid  = (s1_row_q >= ROW_W'(2)) && (s1_row_q <= ROW_W'(eff_h) + ROW_W'(1));
      qr2     = s1_row_q;
      mc      = COL_W'(eff_w - CFG_W'(1));
    end
    p_mid = pm_q;
    pwin  = {p_right[0], p_mid[0], p_left[0],
             p_right[1], p_mid[1], p_left[1],
             p_right[2], p_mid[2], p_left[2]} &
            {{3{p_rowm[0]}}, {3{p_rowm[1]}}, {3{p_rowm[2]}}};
    pixc  = qvalid && pwin[4];
    mark  = pixc && cond_hit(pwin, op_mode_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pl_q <= '0;
      pm_q <= '0;
    end else if (s1_fire) begin
      pl_q <= pm_q;
      pm_q <= pn;
    end
  end

  // ---------------- stage 2: mark window and delete test ----------------
  logic             s2_valid_q, s2_mark_q, s2_pix_q, s2_outv_q, s2_last_q, s2_first_q;
  logic [ROW_W-1:0] s2_qr2_q;
  logic [COL_W-1:0] s2_mc_q;
  logic [3:0]       mark_rdata;
  logic             s2_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      s2_mark_q  <= mark;
      s2_pix_q   <= pixc;
      s2_qr2_q   <= qr2;
      s2_mc_q    <= mc;
      s2_outv_q  <= s1_outv_q;
      s2_last_q  <= s1_last_q;
      s2_first_q <= s1_first_q;
    end
  end

  assign s2_fire = s2_valid_q && adv;

  // mark ram entry: [1:0] {pixel, mark} one row above, [3:2] two rows above
  bsts_ram #(.WIDTH(4), .DEPTH(MAX_WIDTH)) u_mark_ram (
    .clk_i   (clk_i),
    .we_i    (s2_fire),
    .waddr_i (s2_mc_q),
    .wdata_i ({mark_rdata[1:0], s2_pix_q, s2_mark_q}),
    .re_i    (s1_fire),
    .raddr_i (mc),
    .rdata_o (mark_rdata)
  );

  logic [2:0] ml_q, mm_q, mn;
  logic       mpm_q;
  logic [2:0] m_left, m_right, m_rowm;
  logic [8:0] mwin;
  logic       m_c0, del, any_base, any_q, any_d;

  always_comb begin
    mn   = {mark_rdata[2], mark_rdata[0], s2_mark_q};
    m_c0 = (s2_mc_q == '0);
    // qr2 is the mark row plus two, so rows above the frame compare cleanly
    if (!m_c0) begin
      m_rowm  = {s2_qr2_q >= ROW_W'(4), s2_qr2_q >= ROW_W'(3), s2_qr2_q >= ROW_W'(2)};
      m_left  = (s2_mc_q == COL_W'(1)) ? 3'b000 : ml_q;
      m_right = mn;
    end else begin
      m_rowm  = {s2_qr2_q >= ROW_W'(5), s2_qr2_q >= ROW_W'(4), s2_qr2_q >= ROW_W'(3)};
      m_left  = ml_q;
      m_right = 3'b000;
    end
    mwin = {m_right[0], mm_q[0], m_left[0],
            m_right[1], mm_q[1], m_left[1],
            m_right[2], mm_q[2], m_left[2]} &
           {{3{m_rowm[0]}}, {3{m_rowm[1]}}, {3{m_rowm[2]}}};
    del      = s2_outv_q && mwin[4] && !unc_hit(mwin, op_mode_q);
    any_base = s2_first_q ? 1'b0 : any_q;
    any_d    = any_q;
    if (s2_fire) any_d = (s2_outv_q && s2_last_q) ? 1'b0 : (any_base || del);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ml_q  <= '0;
      mm_q  <= '0;
      mpm_q <= 1'b0;
      any_q <= 1'b0;
    end else begin
      any_q <= any_d;
      if (s2_fire) begin
        ml_q  <= mm_q;
        mm_q  <= mn;
        mpm_q <= mark_rdata[1];
      end
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (adv) begin
      out_valid_o <= s2_valid_q && s2_outv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_fire && s2_outv_q) begin
      pixel_out_o     <= mpm_q && !del;
      deleted_o       <= del;
      last_of_frame_o <= s2_last_q;
      frame_changed_o <= s2_last_q && (any_base || del);
    end
  end

endmodule

`default_nettype wire
